/* rtl/crb_pkg.sv */
// Shared types, constants and helpers for the Chebyshev radial basis block.
// Used by every module in rtl/ but crb_fifo; depends on nothing else.
package crb_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_INNER_CUT  = 3'd0;
    localparam logic [2:0] REG_OUTER_CUT  = 3'd1;
    localparam logic [2:0] REG_INV_SPAN   = 3'd2;
    localparam logic [2:0] REG_SCALING    = 3'd3;
    localparam logic [2:0] REG_BASIS_SIZE = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [31:0]        RST_INNER_CUT  = 32'd33554432;
    localparam logic [31:0]        RST_OUTER_CUT  = 32'd83886080;
    localparam logic [31:0]        RST_INV_SPAN   = 32'd11184811;
    localparam logic signed [31:0] RST_SCALING    = 32'sd16777216;
    localparam logic [4:0]         RST_BASIS_SIZE = 5'd8;

    // Widths of the datapath.
    localparam int OPW   = 64;   // multiplier operand, signed
    localparam int PROD_W = 63;  // rounded and clamped product, signed
    localparam int ACC_W = 127;  // full magnitude product
    localparam int VAL_W = 48;   // result value, signed Q16.32

    // Products are clamped to this magnitude before any sum.
    localparam logic [61:0] PROD_LIM = 62'd1 << 61;

    // One in Q8.24 at product width.
    localparam logic signed [PROD_W-1:0] ONE_Q24 = 63'sd16777216;

    // Right shift applied when rounding a product.
    typedef logic [1:0] sh_t;
    localparam sh_t SH_15 = 2'd0;
    localparam sh_t SH_16 = 2'd1;
    localparam sh_t SH_23 = 2'd2;
    localparam sh_t SH_24 = 2'd3;

    // Work item handed from the front part to the back part.
    typedef struct packed {
        logic signed [32:0] e;   // distance minus outer cutoff
        logic signed [32:0] dm;  // distance minus inner cutoff
    } job_t;

    // Request to the shared multiplier.
    typedef struct packed {
        logic signed [OPW-1:0] a;
        logic signed [OPW-1:0] b;
        sh_t                   sh;
    } mul_req_t;

    // One result word.
    typedef struct packed {
        logic [3:0]              basis_index;
        logic signed [VAL_W-1:0] basis_value;
        logic signed [VAL_W-1:0] basis_derivative;
        logic                    last;
    } res_t;

    // Clamp a sum to the signed 48-bit result range.
    function automatic logic signed [VAL_W-1:0] sat48(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< 47) - 64'sd1;
        lo = -(64'sd1 <<< 47);
        if (v > hi) begin
            return VAL_W'(hi);
        end
        if (v < lo) begin
            return VAL_W'(lo);
        end
        return VAL_W'(v);
    endfunction

endpackage

/* rtl/crb_fifo.sv */
// Small flip-flop queue with registered storage and count-based flags.
// Generic; used for the job queue and the result queue. No dependencies.
module crb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/crb_mul.sv */
// Shared multi-cycle multiplier: |a|*|b| from four 32x32 partial products,
// rounded half away from zero, shifted, clamped to 2^61 and signed. Uses crb_pkg.
module crb_mul
    import crb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  mul_req_t                 req,
    output logic                     done,
    output logic signed [PROD_W-1:0] p
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_P0   = 3'd1;
    localparam logic [2:0] M_P1   = 3'd2;
    localparam logic [2:0] M_P2   = 3'd3;
    localparam logic [2:0] M_P3   = 3'd4;
    localparam logic [2:0] M_ACC  = 3'd5;
    localparam logic [2:0] M_RND  = 3'd6;
    localparam logic [2:0] M_OUT  = 3'd7;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic                    done_reg;
    logic                    done_next;
    logic [OPW-1:0]          ma_reg;
    logic [OPW-1:0]          ma_next;
    logic [OPW-1:0]          mb_reg;
    logic [OPW-1:0]          mb_next;
    logic                    neg_reg;
    logic                    neg_next;
    sh_t                     sh_reg;
    sh_t                     sh_next;
    logic [63:0]             prod_reg;
    logic [63:0]             prod_next;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;
    logic [ACC_W-1:0]        rnd_reg;
    logic [ACC_W-1:0]        rnd_next;
    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;
    logic [31:0]             pa;
    logic [31:0]             pb;
    logic [ACC_W-1:0]        half;
    logic [ACC_W-1:0]        quo;
    logic [61:0]             qc;

    assign done = done_reg;
    assign p    = p_reg;

    // Operand halves for the partial product of this step.
    always_comb
    begin
        pa = ma_reg[31:0];
        pb = mb_reg[31:0];
        case (state_reg)
            M_P1:
            begin
                pb = mb_reg[63:32];
            end
            M_P2:
            begin
                pa = ma_reg[63:32];
            end
            M_P3:
            begin
                pa = ma_reg[63:32];
                pb = mb_reg[63:32];
            end
            default:
            begin
                pa = ma_reg[31:0];
                pb = mb_reg[31:0];
            end
        endcase
    end

    always_comb
    begin
        case (sh_reg)
            SH_15:
            begin
                half = ACC_W'(1) << 14;
                quo  = rnd_reg >> 15;
            end
            SH_16:
            begin
                half = ACC_W'(1) << 15;
                quo  = rnd_reg >> 16;
            end
            SH_23:
            begin
                half = ACC_W'(1) << 22;
                quo  = rnd_reg >> 23;
            end
            default:
            begin
                half = ACC_W'(1) << 23;
                quo  = rnd_reg >> 24;
            end
        endcase
        qc = (quo > ACC_W'(PROD_LIM)) ? PROD_LIM : quo[61:0];
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        sh_next    = sh_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        rnd_next   = rnd_reg;
        p_next     = p_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    ma_next    = req.a[OPW-1] ? OPW'(0) - OPW'(req.a) : OPW'(req.a);
                    mb_next    = req.b[OPW-1] ? OPW'(0) - OPW'(req.b) : OPW'(req.b);
                    neg_next   = req.a[OPW-1] ^ req.b[OPW-1];
                    sh_next    = req.sh;
                    state_next = M_P0;
                end
            end
            M_P0:
            begin
                prod_next  = 64'(pa) * 64'(pb);
                state_next = M_P1;
            end
            M_P1:
            begin
                acc_next   = ACC_W'(prod_reg);
                prod_next  = 64'(pa) * 64'(pb);
                state_next = M_P2;
            end
            M_P2:
            begin
                acc_next   = acc_reg + (ACC_W'(prod_reg) << 32);
                prod_next  = 64'(pa) * 64'(pb);
                state_next = M_P3;
            end
            M_P3:
            begin
                acc_next   = acc_reg + (ACC_W'(prod_reg) << 32);
                prod_next  = 64'(pa) * 64'(pb);
                state_next = M_ACC;
            end
            M_ACC:
            begin
                acc_next   = acc_reg + (ACC_W'(prod_reg) << 64);
                state_next = M_RND;
            end
            M_RND:
            begin
                rnd_next   = acc_reg + half;
                state_next = M_OUT;
            end
            M_OUT:
            begin
                p_next     = neg_reg ? PROD_W'(0) - PROD_W'(qc) : PROD_W'(qc);
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg_reg  <= neg_next;
        sh_reg   <= sh_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        rnd_reg  <= rnd_next;
        p_reg    <= p_next;
    end

endmodule

/* rtl/crb_front.sv */
// Front part: takes distance words, forms the offsets from both cutoffs and
// queues them for the back part. Uses crb_pkg and crb_fifo.
module crb_front
    import crb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] distance,
    input  logic [31:0] inner_cut,
    input  logic [31:0] outer_cut,
    input  logic        job_pop,
    output logic        job_valid,
    output job_t        job
);

    job_t                     job_in;
    logic [$bits(job_t)-1:0]  job_raw;
    logic                     job_empty;

    // Both offsets are exact in 33 signed bits.
    assign job_in.e  = $signed({1'b0, distance}) - $signed({1'b0, outer_cut});
    assign job_in.dm = $signed({1'b0, distance}) - $signed({1'b0, inner_cut});

    crb_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (2)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (job_in),
        .full    (full),
        .rd_en   (job_pop),
        .rd_data (job_raw),
        .empty   (job_empty)
    );

    assign job_valid = !job_empty;
    assign job       = job_t'(job_raw);

endmodule

/* rtl/crb_back.sv */
// Back part: sequencer that runs the Chebyshev recurrences for one job at a
// time on the shared multiplier and emits one result word per basis index.
// Uses crb_pkg and crb_mul.
module crb_back
    import crb_pkg::*;
#(
    parameter int MAX_BASIS_SIZE = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  job_t               job,
    output logic               job_pop,
    input  logic [31:0]        inverse_half_span,
    input  logic signed [31:0] scaling,
    input  logic [4:0]         basis_size,
    input  logic               res_full,
    output logic               res_push,
    output res_t               res
);

    localparam int IW = $clog2(MAX_BASIS_SIZE);
    localparam int CW = $clog2(MAX_BASIS_SIZE + 1);
    localparam int NW = (CW > 5) ? CW : 5;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_KSI  = 4'd1;
    localparam logic [3:0] ST_E2   = 4'd2;
    localparam logic [3:0] ST_V0   = 4'd3;
    localparam logic [3:0] ST_D0   = 4'd4;
    localparam logic [3:0] ST_EMIT = 4'd5;
    localparam logic [3:0] ST_T1   = 4'd6;
    localparam logic [3:0] ST_T2   = 4'd7;
    localparam logic [3:0] ST_D1   = 4'd8;
    localparam logic [3:0] ST_V1   = 4'd9;
    localparam logic [3:0] ST_DA   = 4'd10;
    localparam logic [3:0] ST_DB   = 4'd11;
    localparam logic [3:0] ST_VA   = 4'd12;

    logic [3:0]               state_reg;
    logic [3:0]               state_next;
    logic                     issued_reg;
    logic                     issued_next;
    logic [IW-1:0]            idx_reg;
    logic [IW-1:0]            idx_next;
    logic signed [32:0]       e_reg;
    logic signed [32:0]       e_next;
    logic signed [32:0]       dm_reg;
    logic signed [32:0]       dm_next;
    logic signed [41:0]       ksi_reg;
    logic signed [41:0]       ksi_next;
    logic signed [51:0]       e2_reg;
    logic signed [51:0]       e2_next;
    logic signed [63:0]       acc_reg;
    logic signed [63:0]       acc_next;
    logic signed [VAL_W-1:0]  vcur_reg;
    logic signed [VAL_W-1:0]  vcur_next;
    logic signed [VAL_W-1:0]  dcur_reg;
    logic signed [VAL_W-1:0]  dcur_next;
    logic signed [VAL_W-1:0]  v1_reg;
    logic signed [VAL_W-1:0]  v1_next;
    logic signed [VAL_W-1:0]  v2_reg;
    logic signed [VAL_W-1:0]  v2_next;
    logic signed [VAL_W-1:0]  d1_reg;
    logic signed [VAL_W-1:0]  d1_next;
    logic signed [VAL_W-1:0]  d2_reg;
    logic signed [VAL_W-1:0]  d2_next;

    logic                     mul_start;
    mul_req_t                 mul_req;
    logic                     mul_done;
    logic signed [PROD_W-1:0] mul_p;
    logic [NW-1:0]            bs_ext;
    logic [IW-1:0]            last_idx;
    logic                     is_last;

    crb_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .req   (mul_req),
        .done  (mul_done),
        .p     (mul_p)
    );

    // Basis size is clamped to the range two to MAX_BASIS_SIZE.
    assign bs_ext = NW'(basis_size);
    always_comb
    begin
        if (bs_ext < NW'(2))
        begin
            last_idx = IW'(1);
        end
        else if (bs_ext > NW'(MAX_BASIS_SIZE))
        begin
            last_idx = IW'(MAX_BASIS_SIZE - 1);
        end
        else
        begin
            last_idx = IW'(bs_ext - NW'(1));
        end
    end

    assign is_last = (idx_reg == last_idx);

    assign res.basis_index      = 4'(idx_reg);
    assign res.basis_value      = vcur_reg;
    assign res.basis_derivative = dcur_reg;
    assign res.last             = is_last;

    // Operands of the product that belongs to each step.
    always_comb
    begin
        mul_req.a  = '0;
        mul_req.b  = '0;
        mul_req.sh = SH_24;
        case (state_reg)
            ST_KSI:
            begin
                mul_req.a = OPW'(dm_reg);
                mul_req.b = OPW'(inverse_half_span);
            end
            ST_E2:
            begin
                mul_req.a  = OPW'(e_reg);
                mul_req.b  = OPW'(e_reg);
                mul_req.sh = SH_16;
            end
            ST_V0:
            begin
                mul_req.a = OPW'(scaling);
                mul_req.b = OPW'(e2_reg);
            end
            ST_D0:
            begin
                mul_req.a  = OPW'(scaling);
                mul_req.b  = OPW'(e_reg);
                mul_req.sh = SH_15;
            end
            ST_T1:
            begin
                mul_req.a = OPW'(inverse_half_span);
                mul_req.b = OPW'(e2_reg);
            end
            ST_T2:
            begin
                mul_req.a  = OPW'(ksi_reg);
                mul_req.b  = OPW'(e_reg);
                mul_req.sh = SH_15;
            end
            ST_D1:
            begin
                mul_req.a = OPW'(scaling);
                mul_req.b = acc_reg;
            end
            ST_V1:
            begin
                mul_req.a = OPW'(ksi_reg);
                mul_req.b = OPW'(v1_reg);
            end
            ST_DA:
            begin
                mul_req.a  = OPW'(inverse_half_span);
                mul_req.b  = OPW'(v1_reg);
                mul_req.sh = SH_23;
            end
            ST_DB:
            begin
                mul_req.a  = OPW'(ksi_reg);
                mul_req.b  = OPW'(d1_reg);
                mul_req.sh = SH_23;
            end
            ST_VA:
            begin
                mul_req.a  = OPW'(ksi_reg);
                mul_req.b  = OPW'(v1_reg);
                mul_req.sh = SH_23;
            end
            default:
            begin
                mul_req.sh = SH_24;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        issued_next = issued_reg;
        idx_next    = idx_reg;
        e_next      = e_reg;
        dm_next     = dm_reg;
        ksi_next    = ksi_reg;
        e2_next     = e2_reg;
        acc_next    = acc_reg;
        vcur_next   = vcur_reg;
        dcur_next   = dcur_reg;
        v1_next     = v1_reg;
        v2_next     = v2_reg;
        d1_next     = d1_reg;
        d2_next     = d2_reg;
        mul_start   = 1'b0;
        job_pop     = 1'b0;
        res_push    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    e_next     = job.e;
                    dm_next    = job.dm;
                    idx_next   = '0;
                    state_next = ST_KSI;
                end
            end
            ST_EMIT:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    v2_next  = v1_reg;
                    v1_next  = vcur_reg;
                    d2_next  = d1_reg;
                    d1_next  = dcur_reg;
                    idx_next = idx_reg + IW'(1);
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (idx_reg == '0)
                    begin
                        state_next = ST_T1;
                    end
                    else
                    begin
                        state_next = ST_DA;
                    end
                end
            end
            default:
            begin
                // Every other step issues one product and waits for it.
                if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    case (state_reg)
                        ST_KSI:
                        begin
                            ksi_next   = 42'(mul_p - ONE_Q24);
                            state_next = ST_E2;
                        end
                        ST_E2:
                        begin
                            e2_next    = 52'(mul_p);
                            state_next = ST_V0;
                        end
                        ST_V0:
                        begin
                            vcur_next  = sat48(64'(mul_p));
                            state_next = ST_D0;
                        end
                        ST_D0:
                        begin
                            dcur_next  = sat48(64'(mul_p));
                            state_next = ST_EMIT;
                        end
                        ST_T1:
                        begin
                            acc_next   = 64'(mul_p);
                            state_next = ST_T2;
                        end
                        ST_T2:
                        begin
                            acc_next   = acc_reg + 64'(mul_p);
                            state_next = ST_D1;
                        end
                        ST_D1:
                        begin
                            dcur_next  = sat48(64'(mul_p));
                            state_next = ST_V1;
                        end
                        ST_V1:
                        begin
                            vcur_next  = sat48(64'(mul_p));
                            state_next = ST_EMIT;
                        end
                        ST_DA:
                        begin
                            acc_next   = 64'(mul_p);
                            state_next = ST_DB;
                        end
                        ST_DB:
                        begin
                            dcur_next  = sat48(acc_reg + 64'(mul_p) - 64'(d2_reg));
                            state_next = ST_VA;
                        end
                        ST_VA:
                        begin
                            vcur_next  = sat48(64'(mul_p) - 64'(v2_reg));
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            issued_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg    <= e_next;
        dm_reg   <= dm_next;
        ksi_reg  <= ksi_next;
        e2_reg   <= e2_next;
        acc_reg  <= acc_next;
        vcur_reg <= vcur_next;
        dcur_reg <= dcur_next;
        v1_reg   <= v1_next;
        v2_reg   <= v2_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
    end

endmodule

/* rtl/chebyshev_radial_basis.sv */
// Top level of the Chebyshev radial basis block: configuration registers,
// front part, back part and result queue. Uses crb_pkg and all rtl/ modules.
//
// Usage. Distances (unsigned Q8.24) are pushed in like a queue: a word is
// taken at a clock edge with push high and full low. Results leave like a
// queue: while empty is low the oldest result is on basis_index,
// basis_value, basis_derivative and last, and it is taken at an edge with
// pop high. Each distance yields n results, n being basis_size clamped to
// two through MAX_BASIS_SIZE, with last set on the final one.
// The back part computes every product on one shared multiplier and
// issues each product only after the last one is done, so it works on
// one distance at a time. Two distances can wait in the job queue.
// When the receiver stalls, two results wait in the result queue, then the
// back part holds; the job queue then fills and full rises.
// Reset empties both queues, idles the sequencer and loads the default
// register values. The user must write registers with cfg_we, cfg_index
// and cfg_data only while the block is idle; the block itself does not
// enforce this. Unknown indexes are ignored.
module chebyshev_radial_basis
    import crb_pkg::*;
#(
    parameter int MAX_BASIS_SIZE = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [31:0]        distance,
    output logic               empty,
    input  logic               pop,
    output logic [3:0]         basis_index,
    output logic signed [47:0] basis_value,
    output logic signed [47:0] basis_derivative,
    output logic               last,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    logic [31:0]              inner_cut_reg;
    logic [31:0]              outer_cut_reg;
    logic [31:0]              inv_span_reg;
    logic signed [31:0]       scaling_reg;
    logic [4:0]               basis_size_reg;

    logic                     job_valid;
    logic                     job_pop;
    job_t                     job;
    logic                     res_push;
    logic                     res_full;
    res_t                     res_in;
    logic [$bits(res_t)-1:0]  res_raw;
    res_t                     res_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_cut_reg  <= RST_INNER_CUT;
            outer_cut_reg  <= RST_OUTER_CUT;
            inv_span_reg   <= RST_INV_SPAN;
            scaling_reg    <= RST_SCALING;
            basis_size_reg <= RST_BASIS_SIZE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INNER_CUT:  inner_cut_reg  <= cfg_data;
                REG_OUTER_CUT:  outer_cut_reg  <= cfg_data;
                REG_INV_SPAN:   inv_span_reg   <= cfg_data;
                REG_SCALING:    scaling_reg    <= $signed(cfg_data);
                REG_BASIS_SIZE: basis_size_reg <= cfg_data[4:0];
                default:        basis_size_reg <= basis_size_reg;
            endcase
        end
    end

    crb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .distance   (distance),
        .inner_cut  (inner_cut_reg),
        .outer_cut  (outer_cut_reg),
        .job_pop    (job_pop),
        .job_valid  (job_valid),
        .job        (job)
    );

    crb_back #(
        .MAX_BASIS_SIZE (MAX_BASIS_SIZE)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .job_valid         (job_valid),
        .job               (job),
        .job_pop           (job_pop),
        .inverse_half_span (inv_span_reg),
        .scaling           (scaling_reg),
        .basis_size        (basis_size_reg),
        .res_full          (res_full),
        .res_push          (res_push),
        .res               (res_in)
    );

    crb_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (2)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_raw),
        .empty   (empty)
    );

    assign res_head         = res_t'(res_raw);
    assign basis_index      = res_head.basis_index;
    assign basis_value      = res_head.basis_value;
    assign basis_derivative = res_head.basis_derivative;
    assign last             = res_head.last;

    // The back part never writes a result word into a full queue.
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result word pushed into a full result queue");

    // A job is only taken when one is waiting.
    a_job_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid)
        else $error("job taken from an empty job queue");

    // Taking a job starts a computation, so neither a result nor another job follows at once.
    a_job_then_compute: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> !res_push && !job_pop)
        else $error("sequencer emitted or took a job right after taking one");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for chebyshev_radial_basis: directed and random distances
// against a fixed-point predictor of the Chebyshev basis with cutoff envelope.
// Depends on rtl/crb_pkg.sv and rtl/chebyshev_radial_basis.sv.
`timescale 1ns / 100ps

module testbench;
    import crb_pkg::*;

    localparam int MAX_N = 16;
    localparam longint Q24_ONE = 64'sd16777216;
    localparam longint VAL_HI = (64'sd1 <<< 47) - 64'sd1;
    localparam longint VAL_LO = -(64'sd1 <<< 47);
    localparam logic [127:0] PROD_CAP = 128'd1 << 61;
    localparam logic [2:0] REG_UNUSED_LO = 3'd5;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS = 20;

    typedef struct {
        logic [3:0]         index;
        logic signed [47:0] value;
        logic signed [47:0] deriv;
        logic               last;
    } basis_word_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [31:0]        distance;
    logic               empty;
    logic               pop = 1'b0;
    logic [3:0]         basis_index;
    logic signed [47:0] basis_value;
    logic signed [47:0] basis_derivative;
    logic               last;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // Shadow copy of the configuration registers.
    logic [31:0] cut_inner;
    logic [31:0] cut_outer;
    logic [31:0] span_gain;
    longint      env_scale;
    logic [4:0]  basis_count;

    basis_word_t basis_expected[$];
    basis_word_t basis_want;
    int          mismatch_count = 0;
    int          hold_left = 0;
    int          calm_left = 0;

    chebyshev_radial_basis uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .distance         (distance),
        .empty            (empty),
        .pop              (pop),
        .basis_index      (basis_index),
        .basis_value      (basis_value),
        .basis_derivative (basis_derivative),
        .last             (last),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #4 clk = ~clk;

    // round(a*b / 2^sh) half away from zero, magnitude capped at 2^61.
    function automatic longint prod_round(input longint a, input longint b, input int sh);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic         neg;
        ua = (a < 0) ? 64'(-a) : 64'(a);
        ub = (b < 0) ? 64'(-b) : 64'(b);
        neg = (a < 0) != (b < 0);
        p = {64'd0, ua} * {64'd0, ub};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        if (p > PROD_CAP)
        begin
            p = PROD_CAP;
        end
        return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
    endfunction

    function automatic longint clamp48(input longint v);
        if (v > VAL_HI)
        begin
            return VAL_HI;
        end
        if (v < VAL_LO)
        begin
            return VAL_LO;
        end
        return v;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // Queue the words that one distance must produce under the current registers.
    task automatic predict_basis(input logic [31:0] d);
        longint      dl;
        longint      gain;
        longint      e;
        longint      ksi;
        longint      e2;
        longint      vals [MAX_N];
        longint      ders [MAX_N];
        int          n;
        basis_word_t w;
        dl = longint'({32'd0, d});
        gain = longint'({32'd0, span_gain});
        e = dl - longint'({32'd0, cut_outer});
        ksi = prod_round(dl - longint'({32'd0, cut_inner}), gain, 24) - Q24_ONE;
        e2 = prod_round(e, e, 16);
        n = int'(basis_count);
        if (n < 2)
        begin
            n = 2;
        end
        if (n > MAX_N)
        begin
            n = MAX_N;
        end
        vals[0] = clamp48(prod_round(env_scale, e2, 24));
        vals[1] = clamp48(prod_round(ksi, vals[0], 24));
        ders[0] = clamp48(prod_round(env_scale, e, 15));
        ders[1] = clamp48(prod_round(env_scale,
                                     prod_round(gain, e2, 24) + prod_round(ksi, e, 15), 24));
        for (int i = 2; i < n; i++)
        begin
            vals[i] = clamp48(prod_round(ksi, vals[i - 1], 23) - vals[i - 2]);
            ders[i] = clamp48(prod_round(gain, vals[i - 1], 23) +
                              prod_round(ksi, ders[i - 1], 23) - ders[i - 2]);
        end
        for (int i = 0; i < n; i++)
        begin
            w.index = 4'(i);
            w.value = vals[i][47:0];
            w.deriv = ders[i][47:0];
            w.last = (i == n - 1);
            basis_expected.push_back(w);
        end
    endtask

    task automatic report_mismatch(input string what, input longint want, input longint got);
        if (mismatch_count < 10)
        begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
        mismatch_count++;
    endtask

    // Result checker: a word moves at a rising edge with pop high and empty low.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (basis_expected.size() == 0)
            begin
                report_mismatch("unexpected word, basis_index", -1, basis_index);
            end
            else
            begin
                basis_want = basis_expected.pop_front();
                if (basis_index !== basis_want.index)
                begin
                    report_mismatch("basis_index", basis_want.index, basis_index);
                end
                if (basis_value !== basis_want.value)
                begin
                    report_mismatch("basis_value", basis_want.value, basis_value);
                end
                if (basis_derivative !== basis_want.deriv)
                begin
                    report_mismatch("basis_derivative", basis_want.deriv, basis_derivative);
                end
                if (last !== basis_want.last)
                begin
                    report_mismatch("last", basis_want.last, last);
                end
            end
        end
    end

    // Receiver: random stalls, with occasional stretches of steady popping.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else if (calm_left > 0)
        begin
            pop <= 1'b1;
            calm_left--;
        end
        else if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
        begin
            pop <= 1'b1;
            if ($urandom_range(0, 63) == 0)
            begin
                calm_left = $urandom_range(50, 200);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                hold_left = pick_gap();
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_distance(input logic [31:0] d);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            distance <= $urandom;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        distance <= d;
        predict_basis(d);
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_INNER_CUT:  cut_inner = data;
            REG_OUTER_CUT:  cut_outer = data;
            REG_INV_SPAN:   span_gain = data;
            REG_SCALING:    env_scale = {{32{data[31]}}, data};
            REG_BASIS_SIZE: basis_count = data[4:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_data <= $urandom;
        @(negedge clk);
    endtask

    // Every distance yields words, so the block is idle once all have been popped.
    task automatic wait_idle();
        push <= 1'b0;
        while (basis_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_all(input logic [31:0] inner, input logic [31:0] outer,
                             input logic [31:0] gain, input logic [31:0] scale,
                             input logic [31:0] size);
        write_reg(REG_INNER_CUT, inner);
        write_reg(REG_OUTER_CUT, outer);
        write_reg(REG_INV_SPAN, gain);
        write_reg(REG_SCALING, scale);
        write_reg(REG_BASIS_SIZE, size);
    endtask

    task automatic test_reset_defaults();
        send_distance(32'd0);
        send_distance(32'h0200_0000);
        send_distance(32'h0500_0000);
        send_distance(32'h0380_0000);
        send_distance(32'hFFFF_FFFF);
    endtask

    // Sizes below two and above the maximum are clamped; upper data bits are dropped.
    task automatic test_basis_size_limits();
        logic [4:0] sizes [6];
        sizes = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
        foreach (sizes[k])
        begin
            wait_idle();
            write_reg(REG_BASIS_SIZE, {27'($urandom_range(0, 32'h07FF_FFFF)), sizes[k]});
            send_distance($urandom_range(32'h0200_0000, 32'h0500_0000));
        end
    endtask

    task automatic test_extreme_registers();
        wait_idle();
        write_all(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'd16);
        send_distance(32'd0);
        send_distance(32'hFFFF_FFFF);
        send_distance(32'h8000_0000);
        wait_idle();
        write_all(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd16);
        send_distance(32'd0);
        send_distance(32'hFFFF_FFFF);
        wait_idle();
        write_all(32'h0100_0000, 32'h0300_0000, 32'd0, 32'd0, 32'd4);
        send_distance(32'h0200_0000);
    endtask

    // Writes to indexes past the last register must leave everything alone.
    task automatic test_unused_index();
        wait_idle();
        write_all(32'h0100_0000, 32'h0400_0000, 32'h00AA_AAAB, 32'hFF00_0000, 32'd5);
        for (int k = REG_UNUSED_LO; k <= REG_UNUSED_HI; k++)
        begin
            write_reg(3'(k), $urandom);
        end
        send_distance(32'h0280_0000);
        send_distance(32'h0080_0000);
    endtask

    task automatic test_random_phases();
        logic [31:0] inner;
        logic [31:0] outer;
        logic [31:0] span;
        logic [31:0] gain;
        logic [31:0] scale;
        logic [31:0] size;
        logic        wild;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wild = ($urandom_range(0, 3) == 0);
            if (wild)
            begin
                inner = $urandom;
                outer = $urandom;
                gain = $urandom;
                scale = $urandom;
            end
            else
            begin
                inner = $urandom_range(0, 32'h0300_0000);
                span = $urandom_range(32'h0100_0000, 32'h0600_0000);
                outer = inner + span;
                gain = 32'((64'd1 << 49) / {32'd0, span});
                scale = 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
            end
            size = {27'($urandom_range(0, 32'h07FF_FFFF)), 5'd0};
            if ($urandom_range(0, 7) == 0)
            begin
                size[4:0] = 5'($urandom_range(0, 31));
            end
            else
            begin
                size[4:0] = 5'($urandom_range(2, 6));
            end
            wait_idle();
            write_all(inner, outer, gain, scale, size);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (!wild && $urandom_range(0, 7) != 0)
                begin
                    send_distance($urandom_range(inner, outer));
                end
                else
                begin
                    send_distance($urandom);
                end
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        distance = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cut_inner = 32'd33554432;
        cut_outer = 32'd83886080;
        span_gain = 32'd11184811;
        env_scale = 64'sd16777216;
        basis_count = 5'd8;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_basis_size_limits();
        test_extreme_registers();
        test_unused_index();
        test_random_phases();
        wait_idle();
        // Room for a full run at the largest size to expose stray words.
        repeat (600) @(posedge clk);
        if (mismatch_count == 0 && basis_expected.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("testbench NOT OK");
        $finish;
    end

endmodule
